// ===== rtl/lts_pkg.sv =====
// Shared types and constants for the lottery ticket scheduler.
`default_nettype none
package lts_pkg;

  localparam int PID_W   = 5;
  localparam int TKIN_W  = 16;
  localparam int DRAW_W  = 21;
  localparam int TOTAL_W = 21;
  localparam int STAT_W  = 3;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 21'h1FFFFF;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_DRAW   = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_ID   = 3'd1,
    STAT_CONFLICT = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_RANGE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_WALK,
    S_LINK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic key;
    logic link;
    logic pt;
  } mem_we_t;

endpackage
`default_nettype wire

// ===== rtl/lts_store.sv =====
// Key, link and ticket memories of the scheduler, one shared read address.
`default_nettype none
module lts_store import lts_pkg::*; #(
  parameter int MAX_PROCS   = 32,
  parameter int TICKET_BITS = 16,
  localparam int IW  = $clog2(MAX_PROCS),
  localparam int IDW = $clog2(MAX_PROCS + 1)
) (
  input  wire logic                   clk,
  input  wire mem_we_t                we,
  input  wire logic [IW-1:0]          rd_addr,
  input  wire logic [IW-1:0]          key_waddr,
  input  wire logic [TICKET_BITS-1:0] key_wdata,
  input  wire logic [IW-1:0]          link_waddr,
  input  wire logic [IDW-1:0]         link_wdata,
  input  wire logic [IW-1:0]          pt_waddr,
  input  wire logic [TICKET_BITS-1:0] pt_wdata,
  output logic [TICKET_BITS-1:0]      key_rdata,
  output logic [IDW-1:0]              link_rdata,
  output logic [TICKET_BITS-1:0]      pt_rdata
);

  logic [TICKET_BITS-1:0] key_mem  [MAX_PROCS];
  logic [IDW-1:0]         link_mem [MAX_PROCS];
  logic [TICKET_BITS-1:0] pt_mem   [MAX_PROCS];

  // Write each memory at its own address, read all at one
  always_ff @(posedge clk) begin
    if (we.key) begin
      key_mem[key_waddr] <= key_wdata;
    end
    if (we.link) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (we.pt) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    key_rdata  <= key_mem[rd_addr];
    link_rdata <= link_mem[rd_addr];
    pt_rdata   <= pt_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/lottery_ticket_scheduler.sv =====
// Lottery ticket scheduler: ready list, ticket store and draw sequencer.
// One request is taken at a time and gives one result item. Set-tickets
// sweeps every process slot through the ticket memory.
// Insert walks the list one linked entry a cycle until its place, then
// writes the new entry's link and key and links it behind prev in S_LINK.
// Remove and draw walk to the entry and unlink it in the same cycle.
// Rejected requests go straight to S_DONE. The walk rate is set by the read
// of the link memory, whose registered output addresses the next read.
// A new request is taken while the previous result still waits on m_tvalid.
`default_nettype none
module lottery_ticket_scheduler import lts_pkg::*; #(
  parameter int MAX_PROCS   = 32,
  parameter int TICKET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // process_id [4:0], ticket_count [20:5], draw_value [41:21]
  input  wire logic [47:0] s_tdata,
  // req_type [1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status [2:0], winner_id [7:3], ticket_total [28:8]
  output logic [31:0]      m_tdata
);

  localparam int IW  = $clog2(MAX_PROCS);
  localparam int IDW = $clog2(MAX_PROCS + 1);
  localparam int SW  = TICKET_BITS + IDW;
  localparam int CW  = (SW > TOTAL_W) ? SW : TOTAL_W;
  localparam logic [IDW-1:0] EMPTY = IDW'(MAX_PROCS);

  state_t state, state_next;
  req_t   req;
  logic [IW-1:0]          pid;
  logic [TICKET_BITS-1:0] tk;
  logic [DRAW_W-1:0]      draw_r;
  logic [IDW-1:0]         head, cur, prev, idx;
  logic [SW-1:0]          acc, raw_sum;
  logic [MAX_PROCS-1:0]   queued, pt_valid;
  logic                   sw_v;
  logic [IW-1:0]          sw_i;
  status_t                res_status;
  logic [PID_W-1:0]       res_winner;

  mem_we_t                we;
  logic [IW-1:0]          rd_addr, key_waddr, link_waddr, pt_waddr;
  logic [TICKET_BITS-1:0] key_wdata, pt_wdata, key_rdata, pt_rdata;
  logic [IDW-1:0]         link_wdata, link_rdata;

  // Input fields
  req_t                   req_in;
  logic [IW-1:0]          pid_in;
  logic [TICKET_BITS-1:0] tk_in;
  logic [DRAW_W-1:0]      draw_in;
  logic                   pid_ok_in, accept;
  logic [TOTAL_W-1:0]     total_sat;
  logic [CW-1:0]          raw_ext;

  assign req_in    = req_t'(s_tuser);
  assign pid_in    = IW'(s_tdata[4:0]);
  assign tk_in     = TICKET_BITS'(32'(s_tdata[20:5]));
  assign draw_in   = s_tdata[41:21];
  assign pid_ok_in = (req_in == REQ_DRAW) || (32'(s_tdata[4:0]) < MAX_PROCS);
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Saturate the running sum to the total field
  assign raw_ext   = CW'(raw_sum);
  assign total_sat = (raw_ext > CW'(TOTAL_MAX)) ? TOTAL_MAX : raw_ext[TOTAL_W-1:0];

  // Walk decisions on the entry read for cur
  logic                   cur_ok, ins_stop, hit;
  logic [SW-1:0]          acc_next;
  logic [TICKET_BITS-1:0] sw_val;

  assign cur_ok   = cur < EMPTY;
  assign acc_next = acc + SW'(key_rdata);
  assign ins_stop = !cur_ok || (key_rdata < tk) ||
                    ((key_rdata == tk) && (cur > IDW'(pid)));
  assign hit      = cur_ok && ((req == REQ_REMOVE) ? (cur == IDW'(pid))
                                                   : (CW'(acc_next) > CW'(draw_r)));
  assign sw_val   = pt_valid[sw_i] ? pt_rdata : '0;

  lts_store #(
    .MAX_PROCS  (MAX_PROCS),
    .TICKET_BITS(TICKET_BITS)
  ) u_store (
    .clk       (clk),
    .we        (we),
    .rd_addr   (rd_addr),
    .key_waddr (key_waddr),
    .key_wdata (key_wdata),
    .link_waddr(link_waddr),
    .link_wdata(link_wdata),
    .pt_waddr  (pt_waddr),
    .pt_wdata  (pt_wdata),
    .key_rdata (key_rdata),
    .link_rdata(link_rdata),
    .pt_rdata  (pt_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory controls
  always_comb begin
    state_next = state;
    we         = '0;
    rd_addr    = head[IW-1:0];
    key_waddr  = pid;
    key_wdata  = tk;
    link_waddr = pid;
    link_wdata = cur;
    pt_waddr   = pid_in;
    pt_wdata   = tk_in;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          if (pid_ok_in) begin
            unique case (req_in)
              REQ_SET: begin
                we.pt      = 1'b1;
                state_next = S_SWEEP;
              end
              REQ_INSERT: begin
                if (!queued[pid_in]) state_next = S_WALK;
              end
              REQ_REMOVE: begin
                if (queued[pid_in]) state_next = S_WALK;
              end
              REQ_DRAW: begin
                if (head < EMPTY && draw_in < total_sat) state_next = S_WALK;
              end
            endcase
          end
        end
      end
      S_SWEEP: begin
        rd_addr = idx[IW-1:0];
        if (sw_v && queued[sw_i]) begin
          we.key    = 1'b1;
          key_waddr = sw_i;
          key_wdata = sw_val;
        end
        if (idx == EMPTY && !sw_v) state_next = S_DONE;
      end
      S_WALK: begin
        rd_addr = link_rdata[IW-1:0];
        if (req == REQ_INSERT) begin
          // Point the new entry at the first one it goes before
          if (ins_stop) begin
            we.link    = 1'b1;
            we.key     = 1'b1;
            state_next = S_LINK;
          end
        end else if (!cur_ok) begin
          state_next = S_DONE;
        end else if (hit) begin
          // Unlink cur behind prev
          if (prev != EMPTY) begin
            we.link    = 1'b1;
            link_waddr = prev[IW-1:0];
            link_wdata = link_rdata;
          end
          state_next = S_DONE;
        end
      end
      S_LINK: begin
        if (prev != EMPTY) begin
          we.link    = 1'b1;
          link_waddr = prev[IW-1:0];
          link_wdata = IDW'(pid);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and list state
  always_ff @(posedge clk) begin
    if (rst) begin
      queued   <= '0;
      pt_valid <= '0;
      head     <= EMPTY;
      raw_sum  <= '0;
      m_tvalid <= 1'b0;
      sw_v     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req        <= req_in;
            pid        <= pid_in;
            tk         <= tk_in;
            draw_r     <= draw_in;
            cur        <= head;
            prev       <= EMPTY;
            acc        <= '0;
            idx        <= '0;
            sw_v       <= 1'b0;
            res_winner <= '0;
            priority if (!pid_ok_in) begin
              res_status <= STAT_BAD_ID;
            end else if (req_in == REQ_INSERT && queued[pid_in]) begin
              res_status <= STAT_CONFLICT;
            end else if (req_in == REQ_REMOVE && !queued[pid_in]) begin
              res_status <= STAT_CONFLICT;
            end else if (req_in == REQ_DRAW && head >= EMPTY) begin
              res_status <= STAT_EMPTY;
            end else if (req_in == REQ_DRAW && draw_in >= total_sat) begin
              res_status <= STAT_RANGE;
            end else begin
              res_status <= STAT_OK;
            end
            if (pid_ok_in && req_in == REQ_SET) begin
              pt_valid[pid_in] <= 1'b1;
              raw_sum          <= '0;
            end
          end
        end
        S_SWEEP: begin
          // Advance the read index, then copy and sum the returned count
          if (idx < EMPTY) begin
            idx  <= idx + 1'b1;
            sw_v <= 1'b1;
            sw_i <= idx[IW-1:0];
          end else begin
            sw_v <= 1'b0;
          end
          if (sw_v && queued[sw_i]) raw_sum <= raw_sum + SW'(sw_val);
        end
        S_WALK: begin
          if (req == REQ_INSERT) begin
            if (!ins_stop) begin
              prev <= cur;
              cur  <= link_rdata;
            end
          end else if (!cur_ok) begin
            res_status <= STAT_RANGE;
          end else if (hit) begin
            if (prev == EMPTY) head <= link_rdata;
            queued[cur[IW-1:0]] <= 1'b0;
            raw_sum <= raw_sum - SW'(key_rdata);
            if (req == REQ_DRAW) res_winner <= PID_W'(cur);
          end else begin
            prev <= cur;
            cur  <= link_rdata;
            acc  <= acc_next;
          end
        end
        S_LINK: begin
          if (prev == EMPTY) head <= IDW'(pid);
          queued[pid] <= 1'b1;
          raw_sum     <= raw_sum + SW'(tk);
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, total_sat, res_winner, res_status};
          end
        end
        default: ;
      endcase
    end
  end

  // An empty list and an empty head pointer go together
  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (queued == '0) == (head == EMPTY))
    else $error("head pointer disagrees with queued flags");

  // An accepted item always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted item left no work");

  // A finished result reaches the output register
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!m_tvalid || m_tready)) |=> m_tvalid)
    else $error("result dropped");

endmodule
`default_nettype wire
